// ===== rtl/core/dar_pkg.sv =====
// Shared types and codes for the device address registry.
package dar_pkg;

    localparam logic [1:0] ACT_REGISTER   = 2'd0;
    localparam logic [1:0] ACT_UNREGISTER = 2'd1;
    localparam logic [1:0] ACT_FIND       = 2'd2;

    localparam logic [1:0] KIND_PCI = 2'd0;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  addr_type;
        logic [15:0] pci_domain;
        logic [7:0]  pci_bus;
        logic [4:0]  pci_device;
        logic [2:0]  pci_function;
        logic        handler_given;
        logic [5:0]  slot_in;
    } t_in_word;

    typedef struct packed {
        logic       status;
        logic [5:0] slot_out;
        logic [6:0] live_count;
    } t_out_word;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic [15:0] domain;
        logic [7:0]  bus;
        logic [4:0]  devnum;
        logic [2:0]  func;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic load;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic idx_last;
        logic single;
        logic go_scan;
        logic go_probe;
        logic out_free;
    } t_stat;

endpackage

// ===== rtl/core/dar_ctrl.sv =====
// Sequencing state machine for the device address registry.
module dar_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  dar_pkg::t_stat i_stat,
    output dar_pkg::t_cmd  o_cmd
);
    import dar_pkg::*;

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_WAIT   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = (i_stat.go_scan || i_stat.go_probe) ? S_SCAN : S_COMMIT;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_stat.single || i_stat.idx_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/core/dar_datapath.sv =====
// Slot memory, scan compare, occupancy count and result register.
module dar_datapath #(
    parameter int ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dar_pkg::t_cmd      i_cmd,
    output dar_pkg::t_stat     o_stat,
    input  dar_pkg::t_in_word  i_in_word,
    output dar_pkg::t_out_word o_out_word,
    output logic               o_out_valid,
    input  logic               i_out_ready
);
    import dar_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    t_entry          r_mem [ENTRIES];
    t_entry          r_rd_data;
    logic            r_rd_vld;
    logic [IW-1:0]   r_rd_idx;
    logic [IW-1:0]   r_idx;
    logic            r_hit;
    logic [IW-1:0]   r_hit_idx;
    logic            r_free;
    logic [IW-1:0]   r_free_idx;
    logic            r_range_ok;
    t_in_word        r_req;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    t_out_word       r_out;
    logic            r_out_valid;

    logic            in_range;
    logic            rd_match;
    logic [IW-1:0]   unreg_idx;
    logic            ok;
    logic [IW-1:0]   slot;
    logic            wr_en;
    logic [IW-1:0]   wr_addr;
    t_entry          wr_data;

    assign in_range  = (32'(i_in_word.slot_in) < ENTRIES);
    assign unreg_idx = IW'(r_req.slot_in);

    assign rd_match = r_rd_data.valid && (r_rd_data.kind == r_req.addr_type) &&
                      ((r_req.addr_type != KIND_PCI) ||
                       ((r_rd_data.domain == r_req.pci_domain) &&
                        (r_rd_data.bus == r_req.pci_bus) &&
                        (r_rd_data.devnum == r_req.pci_device) &&
                        (r_rd_data.func == r_req.pci_function)));

    always_comb begin
        ok      = 1'b0;
        slot    = '0;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = '0;
        n_count = r_count;
        if (i_cmd.clear) begin
            wr_en = 1'b1;
        end else if (i_cmd.commit) begin
            unique case (r_req.action)
                ACT_REGISTER: begin
                    if (r_req.handler_given && !r_hit && r_free) begin
                        ok             = 1'b1;
                        slot           = r_free_idx;
                        wr_en          = 1'b1;
                        wr_addr        = r_free_idx;
                        wr_data.valid  = 1'b1;
                        wr_data.kind   = r_req.addr_type;
                        wr_data.domain = r_req.pci_domain;
                        wr_data.bus    = r_req.pci_bus;
                        wr_data.devnum = r_req.pci_device;
                        wr_data.func   = r_req.pci_function;
                        n_count        = r_count + CW'(1);
                    end
                end
                ACT_UNREGISTER: begin
                    if (r_range_ok && !r_free) begin
                        ok      = 1'b1;
                        slot    = unreg_idx;
                        wr_en   = 1'b1;
                        wr_addr = unreg_idx;
                        n_count = r_count - CW'(1);
                    end
                end
                ACT_FIND: begin
                    if (r_hit) begin
                        ok   = 1'b1;
                        slot = r_hit_idx;
                    end
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.step) begin
            r_rd_data <= r_mem[r_idx];
            r_rd_idx  <= r_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_in_word;
        end
        if (r_rd_vld && rd_match && !r_hit) begin
            r_hit_idx <= r_rd_idx;
        end
        if (r_rd_vld && !r_rd_data.valid && !r_free) begin
            r_free_idx <= r_rd_idx;
        end
        if (i_cmd.commit) begin
            r_out.status     <= !ok;
            r_out.slot_out   <= 6'(slot);
            r_out.live_count <= 7'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_rd_vld    <= 1'b0;
            r_hit       <= 1'b0;
            r_free      <= 1'b0;
            r_range_ok  <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.step;
            if (r_rd_vld && rd_match) begin
                r_hit <= 1'b1;
            end
            if (r_rd_vld && !r_rd_data.valid) begin
                r_free <= 1'b1;
            end
            if (i_cmd.load) begin
                r_idx      <= (i_in_word.action == ACT_UNREGISTER && in_range) ?
                              IW'(i_in_word.slot_in) : '0;
                r_hit      <= 1'b0;
                r_free     <= 1'b0;
                r_range_ok <= in_range;
            end else if (i_cmd.step || i_cmd.clear) begin
                r_idx <= r_idx + 1'b1;
            end
            r_count <= n_count;
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.idx_last = (r_idx == IW'(ENTRIES - 1));
    assign o_stat.single   = (r_req.action == ACT_UNREGISTER);
    assign o_stat.go_scan  = (i_in_word.action == ACT_REGISTER) ||
                             (i_in_word.action == ACT_FIND);
    assign o_stat.go_probe = (i_in_word.action == ACT_UNREGISTER) && in_range;
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_word  = r_out;
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/device_address_registry.sv =====
// Top level of the device address registry.
//
// The input channel takes one request word (register, unregister or find an
// address) and the output channel returns one result word per request with
// status, slot and the number of live slots.
// A register or find request reads every slot of the memory once, one slot
// per cycle. An unregister request with an in-range slot reads that one
// slot; an out-of-range unregister or a request with an undefined action
// reads no slot.
// The memory has a single read port, and one request is in work at a
// time.
// After reset the block sweeps every slot of the memory to clear the
// valid marks and accepts no word during that sweep.
// The result sits in an output register, so the next request is accepted
// while a result waits; a stalled receiver only holds back the finish of
// that next request.
module device_address_registry #(
    parameter int ENTRIES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dar_pkg::t_in_word  i_in_word,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output dar_pkg::t_out_word o_out_word,
    output logic               o_out_valid,
    input  logic               i_out_ready
);
    import dar_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    dar_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    dar_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_word   (i_in_word),
        .o_out_word  (o_out_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

endmodule

// ===== rtl/core/dar_checker.sv =====
// Port-level checks for the device address registry and their binding.
module dar_checker #(
    parameter int ENTRIES = 64
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input dar_pkg::t_in_word  i_in_word,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input dar_pkg::t_out_word o_out_word,
    input logic               o_out_valid,
    input logic               i_out_ready
);
    import dar_pkg::*;

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_ready))
        else $error("Block is not quiet after reset.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("Input still ready right after a word was taken.");

    a_out_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("Output valid dropped while stalled.");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_word))
        else $error("Output word changed while stalled.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((ENTRIES > 127) || (32'(o_out_word.live_count) <= ENTRIES)))
        else $error("Live count exceeds the table size.");

endmodule

bind device_address_registry dar_checker #(.ENTRIES(ENTRIES)) u_dar_checker (.*);
